### rtl/ecnaimd_pkg.sv
// ecnaimd_pkg: shared types, register indexes, action codes and window helpers
// for the ecn/delay aimd congestion window core. no dependencies.
`timescale 1ns / 1ps

package ecnaimd_pkg;

    // field widths
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned MTU_W     = 16;
    localparam int unsigned MINWIN_W  = 17;
    localparam int unsigned ACK_W     = 24;
    localparam int unsigned ACT_W     = 2;
    localparam int unsigned CFG_IDX_W = 3;

    // bytes of header allowed on top of the mtu for the minimum window
    localparam logic [MINWIN_W-1:0] HDR_ALLOWANCE = 17'd40;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MTU        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_WIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_RTT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DLY = 3'd4;

    // action codes
    localparam logic [ACT_W-1:0] ACT_ACK  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOSS = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SET  = 2'd2;

    // register reset values
    localparam logic [MTU_W-1:0]  RST_MTU        = 16'd4096;
    localparam logic [WORD_W-1:0] RST_INIT_WIN   = 32'd65536;
    localparam logic [WORD_W-1:0] RST_MAX_WIN    = 32'd1048576;
    localparam logic [WORD_W-1:0] RST_INIT_RTT   = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] RST_TARGET_DLY = 32'd10000;
    // initial window clamped against the reset mtu and maximum
    localparam logic [WORD_W-1:0] RST_WINDOW     = 32'd65536;

    // derived configuration seen by the update logic
    typedef struct packed {
        logic [MTU_W-1:0]    mtu;       // effective mtu, zero read as one
        logic [MINWIN_W-1:0] min_win;
        logic [WORD_W-1:0]   max_win;   // never below min_win
        logic [WORD_W-1:0]   target;
    } t_cfg;

    // flow state
    typedef struct packed {
        logic [WORD_W-1:0] window;
        logic [WORD_W-1:0] bytes_acked;
        logic [WORD_W-1:0] min_rtt;
    } t_state;

    // one input word
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [ACK_W-1:0]  acked_bytes;
        logic              ecn_mark;
        logic [WORD_W-1:0] rtt_sample;
        logic [WORD_W-1:0] new_window;
    } t_item;

    // effective mtu, minimum and maximum windows from raw register values
    function automatic t_cfg cfg_derive(
        input logic [MTU_W-1:0]  mtu_raw,
        input logic [WORD_W-1:0] max_raw,
        input logic [WORD_W-1:0] target
    );
        t_cfg c;
        c.mtu     = (mtu_raw == '0) ? MTU_W'(1) : mtu_raw;
        c.min_win = {1'b0, c.mtu} + HDR_ALLOWANCE;
        c.max_win = (max_raw < WORD_W'(c.min_win)) ? WORD_W'(c.min_win) : max_raw;
        c.target  = target;
        return c;
    endfunction

    // clamp a window into [lo, hi]
    function automatic logic [WORD_W-1:0] clamp_win(
        input logic [WORD_W-1:0]   v,
        input logic [MINWIN_W-1:0] lo,
        input logic [WORD_W-1:0]   hi
    );
        logic [WORD_W-1:0] r;
        if (v < WORD_W'(lo)) begin
            r = WORD_W'(lo);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

### rtl/ecnaimd_cfg.sv
// ecnaimd_cfg: configuration registers, derived window limits and the state
// reload word issued on every write to a defined register. depends on ecnaimd_pkg.
`timescale 1ns / 1ps

module ecnaimd_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ecnaimd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ecnaimd_pkg::WORD_W-1:0]      i_cfg_data,
    output ecnaimd_pkg::t_cfg                   o_cfg,
    output logic                                o_reload,
    output ecnaimd_pkg::t_state                 o_reload_state
);

    logic [ecnaimd_pkg::MTU_W-1:0]  r_mtu, n_mtu;
    logic [ecnaimd_pkg::WORD_W-1:0] r_init_win, n_init_win;
    logic [ecnaimd_pkg::WORD_W-1:0] r_max_win, n_max_win;
    logic [ecnaimd_pkg::WORD_W-1:0] r_init_rtt, n_init_rtt;
    logic [ecnaimd_pkg::WORD_W-1:0] r_target, n_target;
    logic                           w_hit;
    ecnaimd_pkg::t_cfg              w_next_cfg;

    // register write decode
    always_comb begin
        n_mtu      = r_mtu;
        n_init_win = r_init_win;
        n_max_win  = r_max_win;
        n_init_rtt = r_init_rtt;
        n_target   = r_target;
        w_hit      = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                ecnaimd_pkg::CFG_MTU: begin
                    n_mtu = i_cfg_data[ecnaimd_pkg::MTU_W-1:0];
                    w_hit = 1'b1;
                end
                ecnaimd_pkg::CFG_INIT_WIN: begin
                    n_init_win = i_cfg_data;
                    w_hit      = 1'b1;
                end
                ecnaimd_pkg::CFG_MAX_WIN: begin
                    n_max_win = i_cfg_data;
                    w_hit     = 1'b1;
                end
                ecnaimd_pkg::CFG_INIT_RTT: begin
                    n_init_rtt = i_cfg_data;
                    w_hit      = 1'b1;
                end
                ecnaimd_pkg::CFG_TARGET_DLY: begin
                    n_target = i_cfg_data;
                    w_hit    = 1'b1;
                end
                default: begin
                    w_hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mtu      <= ecnaimd_pkg::RST_MTU;
            r_init_win <= ecnaimd_pkg::RST_INIT_WIN;
            r_max_win  <= ecnaimd_pkg::RST_MAX_WIN;
            r_init_rtt <= ecnaimd_pkg::RST_INIT_RTT;
            r_target   <= ecnaimd_pkg::RST_TARGET_DLY;
        end else begin
            r_mtu      <= n_mtu;
            r_init_win <= n_init_win;
            r_max_win  <= n_max_win;
            r_init_rtt <= n_init_rtt;
            r_target   <= n_target;
        end
    end

    // limits for the update path come from the stored registers
    assign o_cfg = ecnaimd_pkg::cfg_derive(r_mtu, r_max_win, r_target);

    // reload word built from the values being written, so it lands on the same edge
    assign w_next_cfg = ecnaimd_pkg::cfg_derive(n_mtu, n_max_win, n_target);
    assign o_reload   = w_hit;

    always_comb begin
        o_reload_state.window      = ecnaimd_pkg::clamp_win(n_init_win, w_next_cfg.min_win,
                                                            w_next_cfg.max_win);
        o_reload_state.bytes_acked = '0;
        o_reload_state.min_rtt     = n_init_rtt;
    end

endmodule

### rtl/ecnaimd_upd.sv
// ecnaimd_upd: next flow state for one input word (ack, loss or set window).
// purely combinational. depends on ecnaimd_pkg.
`timescale 1ns / 1ps

module ecnaimd_upd (
    input  ecnaimd_pkg::t_cfg   i_cfg,
    input  ecnaimd_pkg::t_state i_state,
    input  ecnaimd_pkg::t_item  i_item,
    output ecnaimd_pkg::t_state o_state
);

    logic [ecnaimd_pkg::WORD_W-1:0] w_min_rtt;
    logic [ecnaimd_pkg::WORD_W-1:0] w_qdelay;
    logic [ecnaimd_pkg::WORD_W-1:0] w_lo;
    logic [ecnaimd_pkg::WORD_W-1:0] w_half;
    logic [ecnaimd_pkg::WORD_W-1:0] w_dec_win;
    logic [ecnaimd_pkg::WORD_W:0]   w_sum_wide;
    logic [ecnaimd_pkg::WORD_W-1:0] w_sum;
    logic [ecnaimd_pkg::WORD_W:0]   w_grown_wide;
    logic [ecnaimd_pkg::WORD_W-1:0] w_grown_win;

    // minimum rtt tracking; sample never below the new minimum
    assign w_min_rtt = (i_item.rtt_sample < i_state.min_rtt) ? i_item.rtt_sample
                                                             : i_state.min_rtt;
    assign w_qdelay  = i_item.rtt_sample - w_min_rtt;

    // multiplicative decrease, floored at the minimum window
    assign w_lo      = ecnaimd_pkg::WORD_W'(i_cfg.min_win);
    assign w_half    = {1'b0, i_state.window[ecnaimd_pkg::WORD_W-1:1]};
    assign w_dec_win = (w_half < w_lo) ? w_lo : w_half;

    // saturating acked byte counter
    assign w_sum_wide = {1'b0, i_state.bytes_acked}
                      + (ecnaimd_pkg::WORD_W + 1)'(i_item.acked_bytes);
    assign w_sum      = w_sum_wide[ecnaimd_pkg::WORD_W] ? '1
                                                        : w_sum_wide[ecnaimd_pkg::WORD_W-1:0];

    // additive increase, capped at the maximum window
    assign w_grown_wide = {1'b0, i_state.window} + (ecnaimd_pkg::WORD_W + 1)'(i_cfg.mtu);
    assign w_grown_win  = (w_grown_wide > {1'b0, i_cfg.max_win})
                        ? i_cfg.max_win : w_grown_wide[ecnaimd_pkg::WORD_W-1:0];

    // action decode
    always_comb begin
        o_state = i_state;
        unique case (i_item.action)
            ecnaimd_pkg::ACT_ACK: begin
                o_state.min_rtt = w_min_rtt;
                if (i_item.ecn_mark) begin
                    if (w_qdelay >= i_cfg.target) begin
                        o_state.window      = w_dec_win;
                        o_state.bytes_acked = '0;
                    end
                end else if (w_sum >= i_state.window) begin
                    o_state.window      = w_grown_win;
                    o_state.bytes_acked = '0;
                end else begin
                    o_state.bytes_acked = w_sum;
                end
            end
            ecnaimd_pkg::ACT_LOSS: begin
                o_state.window      = w_dec_win;
                o_state.bytes_acked = '0;
            end
            ecnaimd_pkg::ACT_SET: begin
                o_state.window      = ecnaimd_pkg::clamp_win(i_item.new_window, i_cfg.min_win,
                                                             i_cfg.max_win);
                o_state.bytes_acked = '0;
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

### rtl/ecn_delay_aimd_window_core.sv
// ecn_delay_aimd_window_core: top level of the per-flow aimd congestion window.
// depends on ecnaimd_pkg, ecnaimd_cfg and ecnaimd_upd.
//
//   channel   handshake                 payload
//   -------   -----------------------   ------------------------------------------
//   input     i_in_valid / o_in_stall   i_action i_acked_bytes i_ecn_mark
//                                       i_rtt_sample_ns i_new_window_bytes
//   output    o_out_valid / i_out_stall o_window_bytes o_base_rtt_ns
//   config    i_cfg_we                  i_cfg_index i_cfg_data
//
// one word per cycle sustained while the output is not stalled; an accepted word passes
// through the input register, then the state update and result register in one pass.
// the flow state register feeds straight back into the update, so consecutive words do not wait on each other.
// synchronous active-low reset loads the register defaults and the reset state.
// a stalled result holds the output register; the input stalls only when the input
// register is full and the result register cannot drain.
`timescale 1ns / 1ps

module ecn_delay_aimd_window_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [ecnaimd_pkg::ACT_W-1:0]       i_action,
    input  logic [ecnaimd_pkg::ACK_W-1:0]       i_acked_bytes,
    input  logic                                i_ecn_mark,
    input  logic [ecnaimd_pkg::WORD_W-1:0]      i_rtt_sample_ns,
    input  logic [ecnaimd_pkg::WORD_W-1:0]      i_new_window_bytes,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [ecnaimd_pkg::WORD_W-1:0]      o_window_bytes,
    output logic [ecnaimd_pkg::WORD_W-1:0]      o_base_rtt_ns,
    // configuration port
    input  logic                                i_cfg_we,
    input  logic [ecnaimd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ecnaimd_pkg::WORD_W-1:0]      i_cfg_data
);

    ecnaimd_pkg::t_cfg   w_cfg;
    logic                w_reload;
    ecnaimd_pkg::t_state w_reload_state;
    ecnaimd_pkg::t_state r_state;
    ecnaimd_pkg::t_state w_upd_state;
    ecnaimd_pkg::t_item  r_item;
    logic                r_in_valid;
    logic                r_out_valid;
    logic [ecnaimd_pkg::WORD_W-1:0] r_window_out;
    logic [ecnaimd_pkg::WORD_W-1:0] r_rtt_out;
    logic                w_out_busy;
    logic                w_adv;

    // configuration registers
    ecnaimd_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_cfg          (w_cfg),
        .o_reload       (w_reload),
        .o_reload_state (w_reload_state)
    );

    // handshake control
    assign w_out_busy = r_out_valid && i_out_stall;
    assign w_adv      = r_in_valid && !w_out_busy;
    assign o_in_stall = r_in_valid && w_out_busy;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item.action      <= i_action;
            r_item.acked_bytes <= i_acked_bytes;
            r_item.ecn_mark    <= i_ecn_mark;
            r_item.rtt_sample  <= i_rtt_sample_ns;
            r_item.new_window  <= i_new_window_bytes;
        end
    end

    // state update
    ecnaimd_upd u_upd (
        .i_cfg   (w_cfg),
        .i_state (r_state),
        .i_item  (r_item),
        .o_state (w_upd_state)
    );

    // flow state, reloaded on any write to a defined register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.window      <= ecnaimd_pkg::RST_WINDOW;
            r_state.bytes_acked <= '0;
            r_state.min_rtt     <= ecnaimd_pkg::RST_INIT_RTT;
        end else if (w_reload) begin
            r_state <= w_reload_state;
        end else if (w_adv) begin
            r_state <= w_upd_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!w_out_busy) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_window_out <= w_upd_state.window;
            r_rtt_out    <= w_upd_state.min_rtt;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_window_bytes = r_window_out;
    assign o_base_rtt_ns  = r_rtt_out;

    // window always inside the configured limits
    a_win_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.window >= ecnaimd_pkg::WORD_W'(w_cfg.min_win))
        && (r_state.window <= w_cfg.max_win))
        else $error("window outside limits");

    // counter is cleared before it can reach the window
    a_cnt_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bytes_acked < r_state.window)
        else $error("acked byte counter reached window");

    // minimum rtt only falls, except on a reload
    a_rtt_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg_we |=> (r_state.min_rtt <= $past(r_state.min_rtt)))
        else $error("minimum rtt rose without reload");

    // a word leaving the input register shows up as a result next cycle
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (r_out_valid && (r_window_out == $past(w_upd_state.window))))
        else $error("result not delivered after update");

endmodule
